[design/xbt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbt_pkg
// Shared types, character codes and helpers for the xml byte tokenizer.
// ----------------------------------------------------------------------------
package xbt_pkg;

	localparam int OFFSET_BITS_DEF = 24;
	localparam int FIELD_W         = 24;
	localparam int MAX_RES         = 4;
	localparam int IDX_W           = $clog2(MAX_RES);
	localparam int CNT_W           = $clog2(MAX_RES + 1);
	localparam int Q_DEPTH         = 4;

	typedef logic [7:0]         byte_t;
	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	// character codes
	localparam byte_t CH_LT    = 8'h3C;
	localparam byte_t CH_GT    = 8'h3E;
	localparam byte_t CH_SLASH = 8'h2F;
	localparam byte_t CH_QUEST = 8'h3F;
	localparam byte_t CH_BANG  = 8'h21;
	localparam byte_t CH_DASH  = 8'h2D;
	localparam byte_t CH_EQ    = 8'h3D;
	localparam byte_t CH_QUOTE = 8'h22;
	localparam byte_t CH_LF    = 8'h0A;
	localparam byte_t CH_SP    = 8'h20;
	localparam byte_t CH_TAB   = 8'h09;
	localparam byte_t CH_VT    = 8'h0B;
	localparam byte_t CH_FF    = 8'h0C;
	localparam byte_t CH_CR    = 8'h0D;

	typedef enum logic [3:0] {
		K_OPEN       = 4'd0,
		K_END_OPEN   = 4'd1,
		K_CLOSE      = 4'd2,
		K_SELF_CLOSE = 4'd3,
		K_PI_OPEN    = 4'd4,
		K_PI_CLOSE   = 4'd5,
		K_EQUALS     = 4'd6,
		K_NAME       = 4'd7,
		K_STRING     = 4'd8,
		K_TEXT       = 4'd9,
		K_EOF        = 4'd10
	} kind_t;

	typedef enum logic [9:0] {
		M_IDLE      = 10'b00_0000_0001,
		M_NAME      = 10'b00_0000_0010,
		M_TEXT      = 10'b00_0000_0100,
		M_STRING    = 10'b00_0000_1000,
		M_COMMENT   = 10'b00_0001_0000,
		M_LT        = 10'b00_0010_0000,
		M_BANG      = 10'b00_0100_0000,
		M_BANG_DASH = 10'b00_1000_0000,
		M_SLASH     = 10'b01_0000_0000,
		M_QUEST     = 10'b10_0000_0000
	} mode_t;

	typedef struct packed {
		kind_t  kind;
		field_t start;
		field_t length;
		field_t line;
	} token_t;

	// all tokens caused by one byte, last_idx is count minus one
	typedef struct packed {
		idx_t                       last_idx;
		token_t [MAX_RES-1:0]       tok;
	} bundle_t;

	typedef struct packed {
		logic    push;
		bundle_t bundle;
	} q_wr_t;

	typedef struct packed {
		logic    empty;
		bundle_t head;
	} q_rd_t;

	function automatic logic is_ws(input byte_t b);
		return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_VT ||
			b == CH_FF || b == CH_CR;
	endfunction

	function automatic logic is_name_end(input byte_t b);
		return is_ws(b) || b == CH_EQ || b == CH_GT || b == CH_SLASH;
	endfunction

endpackage

[design/xbt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbt_if
// Valid/ready channels for document bytes and for tokens.
// ----------------------------------------------------------------------------
interface xbt_byte_if;
	logic          valid;
	logic          ready;
	xbt_pkg::byte_t byte_value;
	logic          last_byte;

	modport source (output valid, byte_value, last_byte, input ready);
	modport sink   (input valid, byte_value, last_byte, output ready);
endinterface

interface xbt_token_if;
	logic                 valid;
	logic                 ready;
	xbt_pkg::kind_t       token_kind;
	xbt_pkg::field_t      token_start;
	xbt_pkg::field_t      token_length;
	xbt_pkg::field_t      token_line;
	logic                 last_token;

	modport source (output valid, token_kind, token_start, token_length, token_line,
		last_token, input ready);
	modport sink   (input valid, token_kind, token_start, token_length, token_line,
		last_token, output ready);
endinterface

[design/xbt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbt_front
// Lexer front end: one byte per cycle when not full, builds the token bundles.
// ----------------------------------------------------------------------------
module xbt_front #(
	parameter int OFFSET_BITS = xbt_pkg::OFFSET_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	xbt_byte_if.sink          byte_stream,
	input  logic              full,
	output xbt_pkg::q_wr_t    wr
);

	localparam logic [1:0] DASH_MAX = 2'd2;

	typedef logic [OFFSET_BITS-1:0] ofs_t;

	logic             in_q;
	xbt_pkg::mode_t   mode_q;
	ofs_t             pos_q, line_q, tb_q, tbl_q;
	logic [1:0]       dash_q;

	logic             nin;
	xbt_pkg::mode_t   nmode;
	ofs_t             npos, nline, ntb, ntbl, hpos;
	logic [1:0]       nd;
	logic             run_idle;
	xbt_pkg::byte_t   b;
	logic             acc;
	xbt_pkg::token_t [xbt_pkg::MAX_RES-1:0] toks;
	xbt_pkg::cnt_t    n;

	function automatic ofs_t sat_inc(input ofs_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic ofs_t diff(input ofs_t hi, input ofs_t lo);
		return (hi >= lo) ? hi - lo : '0;
	endfunction

	function automatic xbt_pkg::token_t mk(input xbt_pkg::kind_t k, input ofs_t s,
		input ofs_t l, input ofs_t ln);
		xbt_pkg::token_t t;
		t.kind   = k;
		t.start  = xbt_pkg::field_t'(s);
		t.length = xbt_pkg::field_t'(l);
		t.line   = xbt_pkg::field_t'(ln);
		return t;
	endfunction

	assign b   = byte_stream.byte_value;
	assign byte_stream.ready = !full;
	assign acc = byte_stream.valid && !full;

	always_comb begin
		nin      = in_q;
		nmode    = mode_q;
		ntb      = tb_q;
		ntbl     = tbl_q;
		nd       = dash_q;
		npos     = sat_inc(pos_q);
		nline    = (b == xbt_pkg::CH_LF) ? sat_inc(line_q) : line_q;
		hpos     = sat_inc(sat_inc(tb_q));
		run_idle = 1'b0;
		toks     = '0;
		n        = '0;

		// mode-specific handling of the byte
		unique case (mode_q)
			xbt_pkg::M_NAME: begin
				if (xbt_pkg::is_name_end(b)) begin
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_NAME, tb_q,
						diff(pos_q, tb_q), tbl_q);
					n = n + xbt_pkg::cnt_t'(1);
					run_idle = 1'b1;
				end
			end
			xbt_pkg::M_TEXT: begin
				if (b == xbt_pkg::CH_LT) begin
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_TEXT, tb_q,
						diff(pos_q, tb_q), tbl_q);
					n = n + xbt_pkg::cnt_t'(1);
					run_idle = 1'b1;
				end
			end
			xbt_pkg::M_STRING: begin
				if (b == xbt_pkg::CH_QUOTE) begin
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_STRING, tb_q,
						diff(pos_q, tb_q), tbl_q);
					n = n + xbt_pkg::cnt_t'(1);
					nmode = xbt_pkg::M_IDLE;
				end
			end
			xbt_pkg::M_COMMENT: begin
				if (b == xbt_pkg::CH_DASH) begin
					if (dash_q < DASH_MAX) nd = dash_q + 2'd1;
				end else if (b == xbt_pkg::CH_GT && dash_q >= DASH_MAX) begin
					nin   = 1'b0;
					nd    = '0;
					nmode = xbt_pkg::M_IDLE;
				end else begin
					nd = '0;
				end
			end
			xbt_pkg::M_LT: begin
				if (b == xbt_pkg::CH_SLASH) begin
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_END_OPEN, tb_q, '0, tbl_q);
					n = n + xbt_pkg::cnt_t'(1);
					nmode = xbt_pkg::M_IDLE;
				end else if (b == xbt_pkg::CH_QUEST) begin
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_PI_OPEN, tb_q, '0, tbl_q);
					n = n + xbt_pkg::cnt_t'(1);
					nmode = xbt_pkg::M_IDLE;
				end else if (b == xbt_pkg::CH_BANG) begin
					nmode = xbt_pkg::M_BANG;
				end else begin
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_OPEN, tb_q, '0, tbl_q);
					n = n + xbt_pkg::cnt_t'(1);
					run_idle = 1'b1;
				end
			end
			xbt_pkg::M_BANG: begin
				if (b == xbt_pkg::CH_DASH) begin
					nmode = xbt_pkg::M_BANG_DASH;
				end else begin
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_OPEN, tb_q, '0, tbl_q);
					n = n + xbt_pkg::cnt_t'(1);
					run_idle = 1'b1;
				end
			end
			xbt_pkg::M_BANG_DASH: begin
				if (b == xbt_pkg::CH_DASH) begin
					nd    = '0;
					nmode = xbt_pkg::M_COMMENT;
				end else begin
					// failed comment opener: tag open, held dash starts a name
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_OPEN, tb_q, '0, tbl_q);
					n = n + xbt_pkg::cnt_t'(1);
					ntb   = hpos;
					nmode = xbt_pkg::M_NAME;
					if (xbt_pkg::is_name_end(b)) begin
						toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_NAME, hpos,
							diff(pos_q, hpos), tbl_q);
						n = n + xbt_pkg::cnt_t'(1);
						run_idle = 1'b1;
					end
				end
			end
			xbt_pkg::M_SLASH, xbt_pkg::M_QUEST: begin
				if (b == xbt_pkg::CH_GT) begin
					nin = 1'b0;
					toks[n[xbt_pkg::IDX_W-1:0]] = mk((mode_q == xbt_pkg::M_SLASH) ?
						xbt_pkg::K_SELF_CLOSE : xbt_pkg::K_PI_CLOSE, tb_q, '0, tbl_q);
					n = n + xbt_pkg::cnt_t'(1);
					nmode = xbt_pkg::M_IDLE;
				end else begin
					run_idle = 1'b1;
				end
			end
			default: run_idle = 1'b1;
		endcase

		// byte seen between tokens
		if (run_idle) begin
			nmode = xbt_pkg::M_IDLE;
			unique case (b)
				xbt_pkg::CH_LT: begin
					nin   = 1'b1;
					nmode = xbt_pkg::M_LT;
					ntb   = pos_q;
					ntbl  = line_q;
				end
				xbt_pkg::CH_GT: begin
					nin = 1'b0;
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_CLOSE, pos_q, '0, line_q);
					n = n + xbt_pkg::cnt_t'(1);
				end
				xbt_pkg::CH_SLASH: begin
					nmode = xbt_pkg::M_SLASH;
					ntb   = pos_q;
					ntbl  = line_q;
				end
				xbt_pkg::CH_QUEST: begin
					nmode = xbt_pkg::M_QUEST;
					ntb   = pos_q;
					ntbl  = line_q;
				end
				xbt_pkg::CH_EQ: begin
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_EQUALS, pos_q, '0, line_q);
					n = n + xbt_pkg::cnt_t'(1);
				end
				xbt_pkg::CH_QUOTE: begin
					nmode = xbt_pkg::M_STRING;
					ntb   = npos;
					ntbl  = line_q;
				end
				default: begin
					if (!xbt_pkg::is_ws(b)) begin
						ntb   = pos_q;
						ntbl  = line_q;
						nmode = nin ? xbt_pkg::M_NAME : xbt_pkg::M_TEXT;
					end
				end
			endcase
		end

		// end of document: flush pending token, then eof
		if (byte_stream.last_byte) begin
			priority case (nmode)
				xbt_pkg::M_NAME: begin
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_NAME, ntb,
						diff(npos, ntb), ntbl);
					n = n + xbt_pkg::cnt_t'(1);
				end
				xbt_pkg::M_TEXT: begin
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_TEXT, ntb,
						diff(npos, ntb), ntbl);
					n = n + xbt_pkg::cnt_t'(1);
				end
				xbt_pkg::M_LT, xbt_pkg::M_BANG: begin
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_OPEN, ntb, '0, ntbl);
					n = n + xbt_pkg::cnt_t'(1);
				end
				xbt_pkg::M_BANG_DASH: begin
					// mode was just entered, so the begin offset is still tb_q
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_OPEN, ntb, '0, ntbl);
					n = n + xbt_pkg::cnt_t'(1);
					toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_NAME, hpos,
						diff(npos, hpos), ntbl);
					n = n + xbt_pkg::cnt_t'(1);
				end
				default: ;
			endcase
			toks[n[xbt_pkg::IDX_W-1:0]] = mk(xbt_pkg::K_EOF, npos, '0, nline);
			n = n + xbt_pkg::cnt_t'(1);
		end
	end

	assign wr.push            = acc && (n != '0);
	assign wr.bundle.tok      = toks;
	assign wr.bundle.last_idx = xbt_pkg::idx_t'(n - xbt_pkg::cnt_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_q   <= 1'b0;
			mode_q <= xbt_pkg::M_IDLE;
			pos_q  <= '0;
			line_q <= ofs_t'(1);
			tb_q   <= '0;
			tbl_q  <= ofs_t'(1);
			dash_q <= '0;
		end else if (acc) begin
			if (byte_stream.last_byte) begin
				in_q   <= 1'b0;
				mode_q <= xbt_pkg::M_IDLE;
				pos_q  <= '0;
				line_q <= ofs_t'(1);
				tb_q   <= '0;
				tbl_q  <= ofs_t'(1);
				dash_q <= '0;
			end else begin
				in_q   <= nin;
				mode_q <= nmode;
				pos_q  <= npos;
				line_q <= nline;
				tb_q   <= ntb;
				tbl_q  <= ntbl;
				dash_q <= nd;
			end
		end
	end

	a_doc_end_reset: assert property (@(posedge clk) disable iff (!arst_n)
		acc && byte_stream.last_byte |=>
			mode_q == xbt_pkg::M_IDLE && pos_q == '0 && line_q == ofs_t'(1))
		else $error("lexer state not back to start after document end");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		acc && byte_stream.last_byte |->
			wr.push && wr.bundle.tok[wr.bundle.last_idx].kind == xbt_pkg::K_EOF)
		else $error("document end without trailing eof token");

	a_pos_mono: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !byte_stream.last_byte |=> pos_q >= $past(pos_q) && line_q >= $past(line_q))
		else $error("position or line counter went backwards");

endmodule

[design/xbt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbt_queue
// Short bundle queue decoupling the lexer from the token emitter.
// ----------------------------------------------------------------------------
module xbt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  xbt_pkg::q_wr_t  wr,
	output logic            full,
	input  logic            pop,
	output xbt_pkg::q_rd_t  rd
);

	localparam int AW = $clog2(xbt_pkg::Q_DEPTH);

	xbt_pkg::bundle_t mem_q [xbt_pkg::Q_DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             do_pop;

	assign full     = cnt_q == (AW + 1)'(xbt_pkg::Q_DEPTH);
	assign rd.empty = cnt_q == '0;
	assign rd.head  = mem_q[rp_q];
	assign do_pop   = pop && !rd.empty;

	always_ff @(posedge clk) begin
		if (wr.push) mem_q[wp_q] <= wr.bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr.push) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			unique case ({wr.push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr.push)
		else $error("bundle written into a full queue");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW + 1)'(xbt_pkg::Q_DEPTH))
		else $error("queue fill count out of range");

endmodule

[design/xbt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbt_back
// Token emitter: walks the head bundle, one token per transaction.
// ----------------------------------------------------------------------------
module xbt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  xbt_pkg::q_rd_t  rd,
	output logic            pop,
	xbt_token_if.source     token_stream
);

	xbt_pkg::idx_t   idx_q;
	xbt_pkg::token_t cur;
	logic            is_last;
	logic            take;

	assign cur     = rd.head.tok[idx_q];
	assign is_last = idx_q == rd.head.last_idx;
	assign take    = token_stream.valid && token_stream.ready;
	assign pop     = take && is_last;

	assign token_stream.valid        = !rd.empty;
	assign token_stream.token_kind   = cur.kind;
	assign token_stream.token_start  = cur.start;
	assign token_stream.token_length = cur.length;
	assign token_stream.token_line   = cur.line;
	assign token_stream.last_token   = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!rd.empty |-> idx_q <= rd.head.last_idx)
		else $error("token index past end of bundle");

endmodule

[design/xml_byte_tokenizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_byte_tokenizer_core
// Streaming xml lexer: document bytes in, lexical tokens out.
// ----------------------------------------------------------------------------
// The core takes one document byte per clock cycle and produces zero to four
// tokens for it (kind, start offset, length, starting line, last-of-byte flag).
// The lexer front end classifies each byte in the cycle it is accepted and
// writes all its tokens as one bundle into a four-entry queue; the back end
// presents one token per output transaction. Input throughput is therefore
// one byte per cycle as long as the queue has room, and output throughput is
// one token per cycle while the receiver is ready; the queue absorbs the bursts
// of a byte that yields several tokens. A token reaches the output from a
// registered queue entry, behind any older bundles still waiting. Positions
// and line numbers saturate at 2^OFFSET_BITS-1 and are reported in 24 bit
// fields. A byte marked last_byte flushes any pending token, ends with an eof
// token and returns the lexer to its start state for the next document.
module xml_byte_tokenizer_core #(
	parameter int OFFSET_BITS = xbt_pkg::OFFSET_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	xbt_byte_if.sink     byte_stream,
	xbt_token_if.source  token_stream
);

	// front to queue: bundle write, back pressure
	xbt_pkg::q_wr_t q_wr;
	logic           q_full;
	// queue to back: head bundle, release
	xbt_pkg::q_rd_t q_rd;
	logic           q_pop;

	// lexer: mode machine, counters and bundle build
	xbt_front #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_stream),
		.full        (q_full),
		.wr          (q_wr)
	);

	// bundle queue between the two sides
	xbt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.full   (q_full),
		.pop    (q_pop),
		.rd     (q_rd)
	);

	// token emitter, one transaction per token
	xbt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd           (q_rd),
		.pop          (q_pop),
		.token_stream (token_stream)
	);

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for xml_byte_tokenizer_core. Document bytes go in over
// the byte channel, tokens come back over the token channel. Each accepted
// byte runs through a lexer model kept in the bench, and every token that
// comes out is compared field by field with the oldest one still owed. A
// short directed table comes first, then random documents built mostly from
// well-formed markup with some noise and truncation, under three idle mixes.
// ----------------------------------------------------------------------------
module testbench;
	import xbt_pkg::*;

	localparam int OFFSET_BITS      = OFFSET_BITS_DEF;
	localparam int RANDOM_PER_PHASE = 100;
	localparam int MAX_REPORTS      = 10;
	localparam int SEND_IDLE [3]    = '{17, 61, 0};
	localparam int RECV_IDLE [3]    = '{61, 17, 0};

	typedef logic [OFFSET_BITS-1:0] ctr_t;

	typedef struct {
		kind_t  kind;
		field_t start;
		field_t length;
		field_t line;
		logic   last;
	} tok_rec_t;

	typedef struct {
		byte_t    value;
		logic     fin;
		logic     typed;
		tok_rec_t want;
	} stim_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	xbt_byte_if  byte_bus ();
	xbt_token_if token_bus ();

	xml_byte_tokenizer_core #(.OFFSET_BITS(OFFSET_BITS)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_stream  (byte_bus),
		.token_stream (token_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// lexer state mirrored in the bench
	logic       in_tag;
	mode_t      lex_mode;
	byte_t      held_byte;
	ctr_t       doc_pos;
	ctr_t       line_no;
	ctr_t       tok_begin;
	ctr_t       tok_line;
	logic [1:0] dash_run;

	tok_rec_t byte_tokens[$];
	tok_rec_t pending_tokens[$];
	byte_t    doc_bytes[$];

	int       send_idle_pct;
	int       recv_idle_pct;
	logic     row_typed;
	tok_rec_t row_expect;
	tok_rec_t no_expect;

	int byte_count;
	int doc_count;
	int token_count;
	int mismatch_count;

	function automatic ctr_t sat_next(ctr_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic ctr_t span(ctr_t hi, ctr_t lo);
		return (hi >= lo) ? hi - lo : '0;
	endfunction

	function automatic logic blank(byte_t b);
		return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_VT || b == CH_FF ||
			b == CH_CR;
	endfunction

	function automatic void add_token(kind_t k, ctr_t s, ctr_t len, ctr_t ln);
		tok_rec_t t;
		t = '{k, field_t'(s), field_t'(len), field_t'(ln), 1'b0};
		if (byte_tokens.size() < MAX_RES)
			byte_tokens.insert(byte_tokens.size(), t);
	endfunction

	function automatic void lexer_clear();
		in_tag    = 1'b0;
		lex_mode  = M_IDLE;
		held_byte = '0;
		doc_pos   = '0;
		line_no   = ctr_t'(1);
		tok_begin = '0;
		tok_line  = ctr_t'(1);
		dash_run  = '0;
	endfunction

	// byte seen between tokens
	function automatic void lex_idle(byte_t b, ctr_t p, ctr_t ln);
		lex_mode = M_IDLE;
		case (b)
			CH_LT: begin
				in_tag    = 1'b1;
				lex_mode  = M_LT;
				tok_begin = p;
				tok_line  = ln;
			end
			CH_GT: begin
				in_tag = 1'b0;
				add_token(K_CLOSE, p, '0, ln);
			end
			CH_SLASH: begin
				lex_mode  = M_SLASH;
				tok_begin = p;
				tok_line  = ln;
			end
			CH_QUEST: begin
				lex_mode  = M_QUEST;
				tok_begin = p;
				tok_line  = ln;
			end
			CH_EQ: add_token(K_EQUALS, p, '0, ln);
			CH_QUOTE: begin
				lex_mode  = M_STRING;
				tok_begin = sat_next(p);
				tok_line  = ln;
			end
			default: begin
				if (!blank(b)) begin
					tok_begin = p;
					tok_line  = ln;
					lex_mode  = in_tag ? M_NAME : M_TEXT;
				end
			end
		endcase
	endfunction

	function automatic void lex_name(byte_t b, ctr_t p, ctr_t ln);
		if (blank(b) || b == CH_EQ || b == CH_GT || b == CH_SLASH) begin
			add_token(K_NAME, tok_begin, span(p, tok_begin), tok_line);
			lex_idle(b, p, ln);
		end
	endfunction

	function automatic void lex_feed(byte_t b, ctr_t p, ctr_t ln);
		ctr_t hp;
		case (lex_mode)
			M_NAME: lex_name(b, p, ln);
			M_TEXT: begin
				if (b == CH_LT) begin
					add_token(K_TEXT, tok_begin, span(p, tok_begin), tok_line);
					lex_idle(b, p, ln);
				end
			end
			M_STRING: begin
				if (b == CH_QUOTE) begin
					add_token(K_STRING, tok_begin, span(p, tok_begin), tok_line);
					lex_mode = M_IDLE;
				end
			end
			M_COMMENT: begin
				if (b == CH_DASH) begin
					if (dash_run < 2'd2)
						dash_run = dash_run + 1'b1;
				end else if (b == CH_GT && dash_run >= 2'd2) begin
					in_tag   = 1'b0;
					dash_run = '0;
					lex_mode = M_IDLE;
				end else begin
					dash_run = '0;
				end
			end
			M_LT: begin
				if (b == CH_SLASH) begin
					add_token(K_END_OPEN, tok_begin, '0, tok_line);
					lex_mode = M_IDLE;
				end else if (b == CH_QUEST) begin
					add_token(K_PI_OPEN, tok_begin, '0, tok_line);
					lex_mode = M_IDLE;
				end else if (b == CH_BANG) begin
					lex_mode = M_BANG;
				end else begin
					add_token(K_OPEN, tok_begin, '0, tok_line);
					lex_idle(b, p, ln);
				end
			end
			M_BANG: begin
				if (b == CH_DASH) begin
					held_byte = b;
					lex_mode  = M_BANG_DASH;
				end else begin
					add_token(K_OPEN, tok_begin, '0, tok_line);
					lex_idle(b, p, ln);
				end
			end
			M_BANG_DASH: begin
				if (b == CH_DASH) begin
					dash_run = '0;
					lex_mode = M_COMMENT;
				end else begin
					// the held dash is replayed two bytes after the '<'
					hp = sat_next(sat_next(tok_begin));
					add_token(K_OPEN, tok_begin, '0, tok_line);
					lex_idle(held_byte, hp, tok_line);
					if (lex_mode == M_NAME)
						lex_name(b, p, ln);
					else
						lex_idle(b, p, ln);
				end
			end
			M_SLASH, M_QUEST: begin
				if (b == CH_GT) begin
					in_tag = 1'b0;
					add_token(lex_mode == M_SLASH ? K_SELF_CLOSE : K_PI_CLOSE, tok_begin, '0,
						tok_line);
					lex_mode = M_IDLE;
				end else begin
					lex_idle(b, p, ln);
				end
			end
			default: lex_idle(b, p, ln);
		endcase
	endfunction

	// tokens caused by one accepted byte, left in byte_tokens
	function automatic void lex_step(byte_t b, logic fin);
		ctr_t p;
		ctr_t stop_pos;
		ctr_t hp;
		byte_tokens.delete();
		p = doc_pos;
		lex_feed(b, p, line_no);
		if (b == CH_LF)
			line_no = sat_next(line_no);
		doc_pos = sat_next(p);
		if (fin) begin
			stop_pos = doc_pos;
			case (lex_mode)
				M_NAME: add_token(K_NAME, tok_begin, span(stop_pos, tok_begin), tok_line);
				M_TEXT: add_token(K_TEXT, tok_begin, span(stop_pos, tok_begin), tok_line);
				M_LT, M_BANG: add_token(K_OPEN, tok_begin, '0, tok_line);
				M_BANG_DASH: begin
					hp = sat_next(sat_next(tok_begin));
					add_token(K_OPEN, tok_begin, '0, tok_line);
					add_token(K_NAME, hp, span(stop_pos, hp), tok_line);
				end
				default: ;
			endcase
			add_token(K_EOF, stop_pos, '0, line_no);
			lexer_clear();
		end
		if (byte_tokens.size() > 0)
			byte_tokens[byte_tokens.size()-1].last = 1'b1;
	endfunction

	function automatic byte_t pick_blank();
		case ($urandom_range(0, 5))
			0: return CH_SP;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic byte_t pick_letter();
		return byte_t'($urandom_range(8'h61, 8'h7A));
	endfunction

	// append one byte to the document being built
	function automatic void put_doc_byte(byte_t b);
		doc_bytes.insert(doc_bytes.size(), b);
	endfunction

	function automatic void add_name();
		int n;
		n = $urandom_range(1, 4);
		repeat (n) put_doc_byte(pick_letter());
	endfunction

	// one random document, mostly markup with random content
	function automatic void compose_document();
		int parts;
		int sel;
		int n;
		int m;
		int cut;
		doc_bytes.delete();
		parts = $urandom_range(1, 6);
		repeat (parts) begin
			sel = $urandom_range(0, 99);
			if (sel < 18) begin
				n = $urandom_range(1, 6);
				repeat (n) put_doc_byte(($urandom_range(0, 3) == 0) ? pick_blank() :
					pick_letter());
			end else if (sel < 42) begin
				put_doc_byte(CH_LT);
				add_name();
				n = $urandom_range(0, 2);
				repeat (n) begin
					put_doc_byte(pick_blank());
					add_name();
					put_doc_byte(CH_EQ);
					put_doc_byte(CH_QUOTE);
					m = $urandom_range(0, 4);
					repeat (m) put_doc_byte(pick_letter());
					put_doc_byte(CH_QUOTE);
				end
				if ($urandom_range(0, 2) == 0)
					put_doc_byte(pick_blank());
				if ($urandom_range(0, 2) == 0)
					put_doc_byte(CH_SLASH);
				put_doc_byte(CH_GT);
			end else if (sel < 54) begin
				put_doc_byte(CH_LT);
				put_doc_byte(CH_SLASH);
				add_name();
				put_doc_byte(CH_GT);
			end else if (sel < 62) begin
				put_doc_byte(CH_LT);
				put_doc_byte(CH_QUEST);
				add_name();
				put_doc_byte(pick_blank());
				put_doc_byte(CH_QUEST);
				put_doc_byte(CH_GT);
			end else if (sel < 70) begin
				put_doc_byte(CH_LT);
				put_doc_byte(CH_BANG);
				put_doc_byte(CH_DASH);
				put_doc_byte(CH_DASH);
				n = $urandom_range(0, 5);
				repeat (n) begin
					case ($urandom_range(0, 3))
						0: put_doc_byte(CH_DASH);
						1: put_doc_byte(CH_GT);
						default: put_doc_byte(pick_letter());
					endcase
				end
				put_doc_byte(CH_DASH);
				put_doc_byte(CH_DASH);
				put_doc_byte(CH_GT);
			end else if (sel < 78) begin
				n = $urandom_range(1, 3);
				repeat (n) put_doc_byte(pick_blank());
			end else if (sel < 88) begin
				n = $urandom_range(1, 4);
				repeat (n) put_doc_byte(byte_t'($urandom_range(0, 255)));
			end else begin
				// broken openers, stray punctuation and lone quotes
				case ($urandom_range(0, 4))
					0: begin
						put_doc_byte(CH_LT);
						put_doc_byte(CH_BANG);
						put_doc_byte(pick_letter());
					end
					1: begin
						put_doc_byte(CH_LT);
						put_doc_byte(CH_BANG);
						put_doc_byte(CH_DASH);
						put_doc_byte(pick_letter());
					end
					2: begin
						put_doc_byte(CH_SLASH);
						put_doc_byte(pick_letter());
					end
					3: put_doc_byte(CH_QUEST);
					default: begin
						put_doc_byte(CH_QUOTE);
						add_name();
					end
				endcase
			end
		end
		// cut some documents short so pending states meet the end of document
		if ($urandom_range(0, 4) == 0) begin
			cut = $urandom_range(1, doc_bytes.size());
			while (doc_bytes.size() > cut)
				void'(doc_bytes.pop_back());
		end
	endfunction

	function automatic stim_row_t plain_row(byte_t b, logic fin);
		return '{b, fin, 1'b0, '{K_EOF, '0, '0, '0, 1'b0}};
	endfunction

	function automatic stim_row_t typed_row(byte_t b, logic fin, kind_t k, int s, int ln);
		return '{b, fin, 1'b1, '{k, field_t'(s), '0, field_t'(ln), 1'b1}};
	endfunction

	task automatic send_byte(byte_t b, logic fin, logic typed, tok_rec_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_bus.valid <= 1'b0;
			@(negedge clk);
		end
		byte_bus.valid      <= 1'b1;
		byte_bus.byte_value <= b;
		byte_bus.last_byte  <= fin;
		row_typed  = typed;
		row_expect = want;
		@(posedge clk);
		while (!byte_bus.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk)
		token_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// prediction on byte transactions, comparison on token transactions
	always @(posedge clk) begin
		tok_rec_t want;
		if (arst_n && byte_bus.valid && byte_bus.ready) begin
			lex_step(byte_bus.byte_value, byte_bus.last_byte);
			if (row_typed)
				pending_tokens.insert(pending_tokens.size(), row_expect);
			else
				foreach (byte_tokens[k])
					pending_tokens.insert(pending_tokens.size(), byte_tokens[k]);
			byte_count++;
			if (byte_bus.last_byte)
				doc_count++;
		end
		if (arst_n && token_bus.valid && token_bus.ready) begin
			token_count++;
			if (pending_tokens.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("token %0d not expected: kind %0d start %0d length %0d line %0d",
						token_count, token_bus.token_kind, token_bus.token_start,
						token_bus.token_length, token_bus.token_line);
			end else begin
				want = pending_tokens.pop_front();
				if (token_bus.token_kind !== want.kind || token_bus.token_start !== want.start ||
						token_bus.token_length !== want.length ||
						token_bus.token_line !== want.line ||
						token_bus.last_token !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("token %0d: expected %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
							token_count, want.kind, want.start, want.length, want.line,
							want.last, token_bus.token_kind, token_bus.token_start,
							token_bus.token_length, token_bus.token_line,
							token_bus.last_token);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		stim_row_t directed_rows[$];
		int        random_sent;
		byte_bus.valid      = 1'b0;
		byte_bus.byte_value = '0;
		byte_bus.last_byte  = 1'b0;
		token_bus.ready     = 1'b0;
		no_expect           = '{K_EOF, '0, '0, '0, 1'b0};
		row_typed           = 1'b0;
		row_expect          = no_expect;
		send_idle_pct       = SEND_IDLE[0];
		recv_idle_pct       = RECV_IDLE[0];
		byte_count          = 0;
		doc_count           = 0;
		token_count         = 0;
		mismatch_count      = 0;
		lexer_clear();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_rows = '{
			// close straight after reset
			typed_row(CH_GT, 1'b0, K_CLOSE, 0, 1),
			// text of the extreme byte values
			plain_row(8'h00, 1'b0),
			plain_row(8'hFF, 1'b0),
			// '<!-' that is not a comment, then a stray slash inside the name
			plain_row(CH_LT, 1'b0),
			plain_row(CH_BANG, 1'b0),
			plain_row(CH_DASH, 1'b0),
			plain_row("x", 1'b0),
			plain_row(CH_SLASH, 1'b0),
			plain_row("a", 1'b0),
			// attribute value across a line break, then pi close
			plain_row(CH_EQ, 1'b0),
			plain_row(CH_QUOTE, 1'b0),
			plain_row(CH_LF, 1'b0),
			plain_row(CH_QUOTE, 1'b0),
			plain_row(CH_QUEST, 1'b0),
			plain_row(CH_GT, 1'b0),
			// comment closed by its own dashes
			plain_row(CH_LT, 1'b0),
			plain_row(CH_BANG, 1'b0),
			plain_row(CH_DASH, 1'b0),
			plain_row(CH_DASH, 1'b0),
			plain_row(CH_DASH, 1'b0),
			plain_row(CH_DASH, 1'b0),
			plain_row(CH_GT, 1'b0),
			// pending text flushed at the end
			plain_row("z", 1'b1),
			// unterminated string gives end of file only
			typed_row(CH_QUOTE, 1'b1, K_EOF, 1, 1),
			// end tag open, self close, pi open flushed by the end
			plain_row(CH_LT, 1'b0),
			plain_row(CH_SLASH, 1'b0),
			plain_row(CH_SLASH, 1'b0),
			plain_row(CH_GT, 1'b0),
			plain_row(CH_LT, 1'b0),
			plain_row(CH_QUEST, 1'b1)
		};
		foreach (directed_rows[r])
			send_byte(directed_rows[r].value, directed_rows[r].fin, directed_rows[r].typed,
				directed_rows[r].want);

		for (int ph = 0; ph < 3; ph++) begin
			// hold the byte side off until the token side has drained
			byte_bus.valid <= 1'b0;
			while (pending_tokens.size() != 0)
				@(posedge clk);
			@(posedge clk);
			send_idle_pct = SEND_IDLE[ph];
			recv_idle_pct = RECV_IDLE[ph];
			@(negedge clk);
			random_sent = 0;
			while (random_sent < RANDOM_PER_PHASE) begin
				compose_document();
				foreach (doc_bytes[k]) begin
					send_byte(doc_bytes[k], k == doc_bytes.size() - 1, 1'b0, no_expect);
					random_sent++;
				end
			end
		end

		byte_bus.valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d bytes in %0d documents, %0d tokens compared, %0d mismatches",
			byte_count, doc_count, token_count, mismatch_count);
		$display("idle mixes run: slow receiver, slow sender, and back to back");
		if (mismatch_count == 0 && pending_tokens.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
